@@ hdl/lqsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link quality statistics monitor package
// Shared types and constants: event codes, register indexes, payload structs.
// ----------------------------------------------------------------------------
package lqsm_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 1;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [2:0] {
      CMD_TIME    = 3'd0,
      CMD_SEND    = 3'd1,
      CMD_SUCCESS = 3'd2,
      CMD_ERROR   = 3'd3,
      CMD_MISS    = 3'd4,
      CMD_CLEAR   = 3'd5
   } cmd_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FAILSAFE_PERIOD = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WINDOW          = 1'b1;

   localparam logic [15:0] RESET_PERIOD_MS = 16'd1000;
   localparam logic [15:0] RESET_WINDOW_MS = 16'd1000;
   localparam logic [9:0]  MS_PER_SECOND   = 10'd1000;
   localparam logic [6:0]  PERCENT_SCALE   = 7'd100;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] now_ms;
      logic [7:0]  telemetry_length;
      logic [15:0] missed_count;
   } req_type;

   typedef struct packed {
      logic        failsafe;
      logic [6:0]  link_quality_pct;
      logic [31:0] telemetry_rate;
      logic [31:0] sent_total;
      logic [31:0] success_total;
      logic [31:0] error_total;
      logic [31:0] missed_total;
   } rsp_type;

endpackage

@@ hdl/lqsm_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link quality statistics monitor divider
// Bit-serial restoring divider, one quotient bit per cycle, 32-bit operands.
// ----------------------------------------------------------------------------
module lqsm_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   import lqsm_pkg::*;

   logic [31:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvsr_ff, dvsr_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] shifted;

   always_comb begin
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      shifted  = {rem_ff, quot_ff[31]};
      trial    = shifted - {1'b0, dvsr_ff};
      if (start) begin
         quot_in  = dividend;
         rem_in   = '0;
         dvsr_in  = divisor;
         count_in = 6'd32;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quot_in = {quot_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quot_in = {quot_ff[30:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && count_ff == 6'd0)
      else $error("divider done while still iterating");
   a_count_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff != 6'd0)
      else $error("divider busy with zero count");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
endmodule

@@ hdl/link_quality_stats_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link quality statistics monitor
// Counts transmitter events, flags failsafe and recomputes link quality and
// telemetry rate once per window.
//
// Usage: one request per event on req_ (valid/ready) carrying cmd, now_ms,
// telemetry_length and missed_count. Each request gives one response on
// rsp_ (valid/ready) with failsafe, quality, rate and the four counters.
// Configuration: csr_we writes the failsafe period (index 0) or window_ms
// (index 1) from csr_wdata; write only while idle.
// Processing: when the rate is due, 1000*bytes is formed by shift-add and the
// bit-serial divider runs 32 steps; when quality is due, 100*s is formed by
// shift-add and divided the same way. One request at a time: a new request is
// taken only in idle, once the previous one has reached its response register.
// The response register frees the datapath: the next request is taken while
// a response still waits, and is held in its final state until rsp_ drains.
// Reset: counters and marks clear, last success time = -1000, registers
// return to 1000 ms.
// ----------------------------------------------------------------------------
module link_quality_stats_monitor (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lqsm_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lqsm_pkg::rsp_type    rsp_data,
   input  logic                 csr_we,
   input  logic [lqsm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [lqsm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);
   import lqsm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_EVENT, ST_RATE_MUL, ST_RATE_DIV, ST_QUAL_CHK, ST_QUAL_MUL,
      ST_QUAL_DIV, ST_FINISH, ST_HOLD
   } state_type;

   state_type   state_ff;
   logic [15:0] period_ff, window_ff;
   req_type     req_ff;
   logic [31:0] attempt_ff, ack_ff, err_ff, miss_ff, last_ack_ff;
   logic [31:0] qack_mark_ff, qfail_mark_ff, qtime_mark_ff;
   logic [6:0]  quality_ff;
   logic [31:0] bytes_total_ff, bytes_mark_ff, rate_ff, rtime_mark_ff;
   logic [31:0] mul_acc_ff, mul_a_ff, div_num_ff, div_den_ff;
   logic [9:0]  mul_b_ff;
   logic [3:0]  mul_cnt_ff;
   logic        div_start_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [31:0] rate_d, qual_d, fails_now, age;
   logic [15:0] qs, qf, qn;
   logic        div_done;
   logic [31:0] div_q;

   assign rate_d    = req_ff.now_ms - rtime_mark_ff;
   assign qual_d    = req_ff.now_ms - qtime_mark_ff;
   assign fails_now = err_ff + miss_ff;
   assign qs        = ack_ff[15:0] - qack_mark_ff[15:0];
   assign qf        = fails_now[15:0] - qfail_mark_ff[15:0];
   assign qn        = qs + qf;
   assign age       = req_ff.now_ms - last_ack_ff;

   lqsm_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (div_num_ff),
      .divisor  (div_den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         div_start_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         period_ff      <= RESET_PERIOD_MS;
         window_ff      <= RESET_WINDOW_MS;
         attempt_ff     <= '0;
         ack_ff         <= '0;
         err_ff         <= '0;
         miss_ff        <= '0;
         last_ack_ff    <= 32'd0 - {16'd0, RESET_PERIOD_MS};
         qack_mark_ff   <= '0;
         qfail_mark_ff  <= '0;
         qtime_mark_ff  <= '0;
         quality_ff     <= '0;
         bytes_total_ff <= '0;
         bytes_mark_ff  <= '0;
         rate_ff        <= '0;
         rtime_mark_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_FAILSAFE_PERIOD: period_ff <= csr_wdata;
               CSR_WINDOW:          window_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready && state_ff != ST_FINISH) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= ST_EVENT;
               end
            end
            ST_EVENT: begin
               case (req_ff.cmd)
                  CMD_SEND: attempt_ff <= attempt_ff + 32'd1;
                  CMD_SUCCESS: begin
                     ack_ff         <= ack_ff + 32'd1;
                     bytes_total_ff <= bytes_total_ff + {24'd0, req_ff.telemetry_length};
                     last_ack_ff    <= req_ff.now_ms;
                  end
                  CMD_ERROR: err_ff <= err_ff + 32'd1;
                  CMD_MISS:  miss_ff <= miss_ff + {16'd0, req_ff.missed_count};
                  CMD_CLEAR: begin
                     attempt_ff     <= '0;
                     ack_ff         <= '0;
                     err_ff         <= '0;
                     miss_ff        <= '0;
                     last_ack_ff    <= req_ff.now_ms - {16'd0, period_ff};
                     qack_mark_ff   <= '0;
                     qfail_mark_ff  <= '0;
                     qtime_mark_ff  <= req_ff.now_ms;
                     quality_ff     <= '0;
                     bytes_total_ff <= '0;
                     bytes_mark_ff  <= '0;
                     rate_ff        <= '0;
                     rtime_mark_ff  <= req_ff.now_ms;
                  end
                  default: ;
               endcase
               state_ff <= ST_RATE_MUL;
               mul_cnt_ff <= 4'd0;
               mul_acc_ff <= '0;
               mul_b_ff   <= MS_PER_SECOND;
               mul_a_ff   <= '0;
            end
            ST_RATE_MUL: begin
               if (rate_d <= {16'd0, window_ff}) begin
                  state_ff <= ST_QUAL_CHK;
               end else if (mul_cnt_ff == 4'd0) begin
                  mul_a_ff   <= bytes_total_ff - bytes_mark_ff;
                  mul_cnt_ff <= 4'd1;
               end else if (mul_cnt_ff <= 4'd10) begin
                  if (mul_b_ff[0]) mul_acc_ff <= mul_acc_ff + mul_a_ff;
                  mul_a_ff   <= {mul_a_ff[30:0], 1'b0};
                  mul_b_ff   <= {1'b0, mul_b_ff[9:1]};
                  mul_cnt_ff <= mul_cnt_ff + 4'd1;
               end else begin
                  div_num_ff   <= mul_acc_ff;
                  div_den_ff   <= rate_d;
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_RATE_DIV;
               end
            end
            ST_RATE_DIV: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  rate_ff       <= div_q;
                  bytes_mark_ff <= bytes_total_ff;
                  rtime_mark_ff <= req_ff.now_ms;
                  state_ff      <= ST_QUAL_CHK;
               end
            end
            ST_QUAL_CHK: begin
               if (qual_d <= {16'd0, window_ff}) begin
                  state_ff <= ST_FINISH;
               end else if (qn == 16'd0) begin
                  quality_ff    <= '0;
                  qack_mark_ff  <= ack_ff;
                  qfail_mark_ff <= fails_now;
                  qtime_mark_ff <= req_ff.now_ms;
                  state_ff      <= ST_FINISH;
               end else begin
                  mul_a_ff   <= {16'd0, qs};
                  mul_b_ff   <= {3'd0, PERCENT_SCALE};
                  mul_acc_ff <= '0;
                  mul_cnt_ff <= 4'd1;
                  state_ff   <= ST_QUAL_MUL;
               end
            end
            ST_QUAL_MUL: begin
               if (mul_cnt_ff <= 4'd7) begin
                  if (mul_b_ff[0]) mul_acc_ff <= mul_acc_ff + mul_a_ff;
                  mul_a_ff   <= {mul_a_ff[30:0], 1'b0};
                  mul_b_ff   <= {1'b0, mul_b_ff[9:1]};
                  mul_cnt_ff <= mul_cnt_ff + 4'd1;
               end else begin
                  div_num_ff   <= mul_acc_ff;
                  div_den_ff   <= {16'd0, qn};
                  div_start_ff <= 1'b1;
                  state_ff     <= ST_QUAL_DIV;
               end
            end
            ST_QUAL_DIV: begin
               div_start_ff <= 1'b0;
               if (div_done) begin
                  quality_ff    <= (div_q > {25'd0, PERCENT_SCALE}) ? PERCENT_SCALE
                                                                   : div_q[6:0];
                  qack_mark_ff  <= ack_ff;
                  qfail_mark_ff <= fails_now;
                  qtime_mark_ff <= req_ff.now_ms;
                  state_ff      <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.failsafe         <= (age >= {16'd0, period_ff});
                  rsp_ff.link_quality_pct <= quality_ff;
                  rsp_ff.telemetry_rate   <= rate_ff;
                  rsp_ff.sent_total       <= attempt_ff;
                  rsp_ff.success_total    <= ack_ff;
                  rsp_ff.error_total      <= err_ff;
                  rsp_ff.missed_total     <= miss_ff;
                  rsp_valid_ff            <= 1'b1;
                  state_ff                <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_quality_bound: assert property (@(posedge clock) disable iff (reset)
      quality_ff <= PERCENT_SCALE)
      else $error("quality above 100 percent");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> state_ff == ST_RATE_DIV || state_ff == ST_QUAL_DIV)
      else $error("divider started outside a divide state");
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("response raised outside finish");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_ready)
      else $error("request accepted while busy");
endmodule

@@ test/tb_link_quality_stats_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link quality statistics monitor testbench
// Drives event requests with random idling on both channels, predicts each
// response from an internal model of the counters, windows and failsafe
// flag, and compares every response field by field in order.
// ----------------------------------------------------------------------------
module tb_link_quality_stats_monitor;
   import lqsm_pkg::*;

   class lqsm_scoreboard;
      logic [15:0] period_ms;
      logic [15:0] window_ms;
      logic [31:0] sent_cnt, ack_cnt, err_cnt, miss_cnt, last_ack;
      logic [31:0] q_ack_mark, q_fail_mark, q_time_mark;
      logic [6:0]  quality;
      logic [31:0] bytes_total, bytes_mark, rate, rate_mark;
      rsp_type     pending[$];
      int          errors;
      int          checked;

      function void clear_all(logic [31:0] t);
         sent_cnt = 0; ack_cnt = 0; err_cnt = 0; miss_cnt = 0;
         last_ack = t - {16'd0, period_ms};
         q_ack_mark = 0; q_fail_mark = 0; q_time_mark = t; quality = '0;
         bytes_total = 0; bytes_mark = 0; rate = 0; rate_mark = t;
      endfunction

      function void reset_state();
         period_ms = RESET_PERIOD_MS;
         window_ms = RESET_WINDOW_MS;
         clear_all(32'd0);
         pending.delete();
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] val);
         if (idx == CSR_FAILSAFE_PERIOD) period_ms = val;
         else window_ms = val;
      endfunction

      function void note_request(req_type r);
         logic [31:0] t, d, fails, s, f, n, q, prod;
         rsp_type     e;
         t = r.now_ms;
         case (r.cmd)
            CMD_SEND:    sent_cnt++;
            CMD_SUCCESS: begin
               ack_cnt++;
               bytes_total += {24'd0, r.telemetry_length};
               last_ack = t;
            end
            CMD_ERROR:   err_cnt++;
            CMD_MISS:    miss_cnt += {16'd0, r.missed_count};
            CMD_CLEAR:   clear_all(t);
            default: ;
         endcase
         d = t - rate_mark;
         if (d > {16'd0, window_ms}) begin
            prod = (bytes_total - bytes_mark) * 32'd1000;
            rate = prod / d;
            bytes_mark = bytes_total;
            rate_mark = t;
         end
         d = t - q_time_mark;
         if (d > {16'd0, window_ms}) begin
            fails = err_cnt + miss_cnt;
            s = (ack_cnt - q_ack_mark) & 32'hFFFF;
            f = (fails - q_fail_mark) & 32'hFFFF;
            n = (s + f) & 32'hFFFF;
            q = 0;
            if (n != 0) begin
               q = (s * 32'd100) / n;
               if (q > 100) q = 100;
            end
            quality = q[6:0];
            q_ack_mark = ack_cnt;
            q_fail_mark = fails;
            q_time_mark = t;
         end
         e.failsafe = ((t - last_ack) >= {16'd0, period_ms});
         e.link_quality_pct = quality;
         e.telemetry_rate = rate;
         e.sent_total = sent_cnt;
         e.success_total = ack_cnt;
         e.error_total = err_cnt;
         e.missed_total = miss_cnt;
         pending.push_back(e);
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (a.failsafe !== e.failsafe) begin
            $display("%0t: failsafe exp %0d got %0d", $time, e.failsafe, a.failsafe);
            errors++;
         end
         if (a.link_quality_pct !== e.link_quality_pct) begin
            $display("%0t: quality exp %0d got %0d", $time, e.link_quality_pct,
                     a.link_quality_pct);
            errors++;
         end
         if (a.telemetry_rate !== e.telemetry_rate) begin
            $display("%0t: rate exp %0d got %0d", $time, e.telemetry_rate,
                     a.telemetry_rate);
            errors++;
         end
         if (a.sent_total !== e.sent_total) begin
            $display("%0t: sent exp %0d got %0d", $time, e.sent_total, a.sent_total);
            errors++;
         end
         if (a.success_total !== e.success_total) begin
            $display("%0t: success exp %0d got %0d", $time, e.success_total,
                     a.success_total);
            errors++;
         end
         if (a.error_total !== e.error_total) begin
            $display("%0t: error exp %0d got %0d", $time, e.error_total,
                     a.error_total);
            errors++;
         end
         if (a.missed_total !== e.missed_total) begin
            $display("%0t: missed exp %0d got %0d", $time, e.missed_total,
                     a.missed_total);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   lqsm_scoreboard stats_sb;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_rsp = 1'b0;
   int  quiet_cycles = 0;
   int  sent_reqs = 0;
   logic [31:0] clock_ms = 0;

   link_quality_stats_monitor DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) stats_sb.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) stats_sb.check_response(rsp_data);
      if (!reset && !((req_valid && req_ready) || (rsp_valid && rsp_ready)))
         quiet_cycles <= quiet_cycles + 1;
      else
         quiet_cycles <= 0;
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_request(req_type r);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_reqs++;
   endtask

   task automatic send_event(cmd_type c, logic [31:0] t, logic [7:0] tl,
                             logic [15:0] mc);
      req_type r;
      r.cmd = c;
      r.now_ms = t;
      r.telemetry_length = tl;
      r.missed_count = mc;
      send_request(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (stats_sb.pending.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      stats_sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic random_event();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      if (pick < 3) clock_ms = $urandom;
      else if (pick < 50) clock_ms += $urandom_range(3);
      else if (pick < 85) clock_ms += $urandom_range(stats_sb.window_ms + 20);
      else clock_ms += $urandom_range(70000);
      r.now_ms = clock_ms;
      r.telemetry_length = 8'($urandom_range(255));
      r.missed_count = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                                : 16'($urandom_range(4));
      pick = $urandom_range(99);
      if (pick < 2) r.cmd = CMD_CLEAR;
      else if (pick < 4) r.cmd = 3'($urandom_range(7, 6));
      else if (pick < 10) r.cmd = CMD_TIME;
      else if (pick < 30) r.cmd = CMD_SEND;
      else if (pick < 65) r.cmd = CMD_SUCCESS;
      else if (pick < 82) r.cmd = CMD_ERROR;
      else r.cmd = CMD_MISS;
      send_request(r);
   endtask

   initial begin
      stats_sb = new();
      stats_sb.reset_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset state, every event, extremes
      send_event(CMD_TIME, 32'd0, 8'd0, 16'd0);
      send_event(CMD_SEND, 32'd500, 8'hFF, 16'hFFFF);
      send_event(CMD_SUCCESS, 32'd600, 8'hFF, 16'hFFFF);
      send_event(CMD_SUCCESS, 32'd700, 8'h00, 16'd0);
      send_event(CMD_ERROR, 32'd800, 8'hAA, 16'h5555);
      send_event(CMD_MISS, 32'd900, 8'h55, 16'hFFFF);
      send_event(CMD_TIME, 32'd1601, 8'd0, 16'd0);
      send_event(CMD_TIME, 32'd3000, 8'd0, 16'd0);
      send_event(cmd_type'(3'd6), 32'hFFFF_FFFF, 8'd0, 16'd0);
      send_event(cmd_type'(3'd7), 32'd5, 8'd0, 16'd0);
      send_event(CMD_CLEAR, 32'h8000_0000, 8'd0, 16'd0);
      send_event(CMD_TIME, 32'h8000_0000, 8'd0, 16'd0);
      // wrapped window total: many misses after a success
      send_event(CMD_SUCCESS, 32'h8000_0001, 8'd1, 16'd0);
      send_event(CMD_MISS, 32'h8000_0002, 8'd0, 16'hFFFF);
      send_event(CMD_TIME, 32'h8000_1000, 8'd0, 16'd0);
      drain();

      write_csr(CSR_WINDOW, 16'd0);
      write_csr(CSR_FAILSAFE_PERIOD, 16'd1);
      send_event(CMD_SUCCESS, 32'd10, 8'd200, 16'd0);
      send_event(CMD_TIME, 32'd11, 8'd0, 16'd0);
      send_event(CMD_SUCCESS, 32'd12, 8'd100, 16'd0);
      send_event(CMD_CLEAR, 32'd20, 8'd0, 16'd0);
      send_event(CMD_TIME, 32'd20, 8'd0, 16'd0);
      drain();

      write_csr(CSR_FAILSAFE_PERIOD, 16'hFFFF);
      write_csr(CSR_WINDOW, 16'hFFFF);
      send_event(CMD_SUCCESS, 32'd100, 8'd7, 16'd0);
      send_event(CMD_TIME, 32'd65636, 8'd0, 16'd0);
      send_event(CMD_TIME, 32'd65637, 8'd0, 16'd0);
      drain();

      // random phases through several register settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin send_idle_pct = 7;  recv_idle_pct = 52; end
            2: begin send_idle_pct = 52; recv_idle_pct = 7;  end
            4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            default: ;
         endcase
         write_csr(CSR_FAILSAFE_PERIOD, 16'($urandom_range(1, 3000)));
         write_csr(CSR_WINDOW, (ph == 5) ? 16'd0 : 16'($urandom_range(1, 2000)));
         if (ph == 3) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (400) @(posedge clock);
                  hold_rsp = 1'b0;
               end
               repeat (20) random_event();
            join
         end
         repeat (105) random_event();
         drain();
      end

      $display("Sent %0d requests, checked %0d responses over all events,",
               sent_reqs, stats_sb.checked);
      $display("window and failsafe extremes, clears and a long response stall.");
      if (stats_sb.errors == 0 && stats_sb.pending.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule

@@ filelist.f @@
hdl/lqsm_pkg.sv
hdl/lqsm_divider.sv
hdl/link_quality_stats_monitor.sv
test/tb_link_quality_stats_monitor.sv
